// ----- rtl/kmns_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmns_pkg
// Shared constants and types of the keyboard matrix nibble scanner.
// ----------------------------------------------------------------------------
package kmns_pkg;

	localparam int unsigned RowCount = 16;
	localparam int unsigned FrameLen = 18;
	localparam int unsigned IdxW     = 5;
	localparam int unsigned CapsRow  = 14;
	localparam int unsigned CapsBit  = 4;

	localparam logic [7:0]      FRAME_MARK = 8'h02;
	localparam logic [IdxW-1:0] IDX_LAST   = IdxW'(FrameLen - 1);

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	typedef struct packed {
		logic load_rows;
		logic load_frame;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/kmns_row_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmns_row_cell
// One matrix row: holds the key row and its inverted frame byte, and passes
// the read byte along the chain.
// ----------------------------------------------------------------------------
module kmns_row_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  kmns_pkg::cell_ctrl_t    ctrl,
	input  wire  [7:0]              row_new,
	input  wire                     rd_match,
	input  wire  [7:0]              rd_in,
	output logic [7:0]              rd_out,
	output logic [7:0]              row
);
	import kmns_pkg::*;

	logic [7:0] row_q;
	logic [7:0] frame_q;
	logic [7:0] frame_next;

	// frame load only happens on port writes, where the row does not change
	assign frame_next = ctrl.load_frame ? ~row_q : frame_q;
	assign rd_out     = rd_match ? frame_next : rd_in;
	assign row        = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			frame_q <= '0;
		end else begin
			if (ctrl.load_rows) begin
				row_q <= row_new;
			end
			frame_q <= frame_next;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/kmns_out_buf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmns_out_buf
// Two-entry output buffer: an output register and a skid register.
// ----------------------------------------------------------------------------
module kmns_out_buf (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	input  wire  [3:0] push_data,
	output logic       full,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [3:0] out_data
);
	import kmns_pkg::*;

	logic       out_valid_q;
	logic [3:0] out_data_q;
	logic       skid_valid_q;
	logic [3:0] skid_data_q;
	logic       take;

	assign take      = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with empty output register");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && take) |=> (out_valid_q && !skid_valid_q))
		else $error("skid word not moved to output");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !take) |=> $stable(skid_data_q))
		else $error("skid word overwritten");
`endif

endmodule

`default_nettype wire

// ----- rtl/keyboard_matrix_nibble_scanner_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyboard_matrix_nibble_scanner_core
// Keyboard matrix scanner: 16 key rows read out as an 18-byte nibble frame.
// ----------------------------------------------------------------------------
// Every accepted word (key update, port line write or read) yields exactly one
// result word, and a new word can be accepted every cycle while the output buffer is not full.
// State lives in a row of 16 identical cells, one per matrix row; each cell
// keeps its key row and the inverted copy that sits in the frame, and the
// frame byte at the current index travels down the cell chain to the output.
// The frame marks (first and last byte, 0x02) appear after the first rising
// clear line; before that they read as zero. Results go into a two-entry
// output buffer, so input is stalled only when two results are waiting.
// ----------------------------------------------------------------------------
module keyboard_matrix_nibble_scanner_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  command,
	input  wire  [63:0] key_rows_low,
	input  wire  [63:0] key_rows_high,
	input  wire         prev_sel,
	input  wire         next_sel,
	input  wire         prev_clr,
	input  wire         next_clr,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [3:0]  read_nibble
);
	import kmns_pkg::*;

	logic                accept;
	logic                buf_full;
	logic                is_update;
	logic                is_write;
	logic                clr_rise;
	logic                sel_rise;
	logic                sel_rise_block;
	logic                wrap;

	logic [IdxW-1:0]     frame_index_q;
	logic [IdxW-1:0]     index_next;
	logic                sel_level_q;
	logic                sel_next;
	logic                last_caps_q;
	logic                marks_q;
	logic                marks_next;

	logic [7:0]          rows_in   [RowCount];
	logic [7:0]          rows_cur  [RowCount];
	logic [7:0]          chain     [RowCount+1];
	logic [RowCount-1:0] rd_match;
	cell_ctrl_t          ctrl;

	logic                caps_key;
	logic                caps_next;
	logic [7:0]          byte_sel;
	logic [3:0]          nibble;

	assign in_stall  = buf_full;
	assign accept    = in_valid && !in_stall;
	assign is_update = accept && (command == CMD_UPDATE);
	assign is_write  = accept && (command == CMD_WRITE);
	assign clr_rise  = is_write && !prev_clr && next_clr;
	assign sel_rise  = is_write && !sel_rise_block && !prev_sel && next_sel;

	// clear wins over select
	assign sel_rise_block = !prev_clr && next_clr;

	assign wrap = sel_rise && (frame_index_q >= IDX_LAST);

	always_comb begin
		index_next = frame_index_q;
		if (clr_rise) begin
			index_next = '0;
		end else if (sel_rise) begin
			index_next = wrap ? '0 : frame_index_q + IdxW'(1);
		end
	end

	assign sel_next   = is_write ? next_sel : sel_level_q;
	assign marks_next = marks_q || clr_rise;

	assign ctrl.load_rows  = is_update;
	assign ctrl.load_frame = clr_rise || wrap;

	// caps lock: toggle the stored bit on each rising edge of the key
	assign caps_key  = key_rows_high[8*(CapsRow-8)+CapsBit];
	assign caps_next = rows_cur[CapsRow][CapsBit] ^ (!last_caps_q && caps_key);

	always_comb begin
		for (int r = 0; r < 8; r++) begin
			rows_in[r]   = key_rows_low[8*r +: 8];
			rows_in[r+8] = key_rows_high[8*r +: 8];
		end
		rows_in[CapsRow][CapsBit] = caps_next;
	end

	// seed the read chain with the frame mark when the index points at one and the marks are set
	assign chain[0] = ((index_next == '0) || (index_next == IDX_LAST)) && marks_next
		? FRAME_MARK : 8'h00;

	for (genvar i = 0; i < RowCount; i++) begin : g_cell
		assign rd_match[i] = (index_next == IdxW'(i + 1));
		kmns_row_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.row_new  (rows_in[i]),
			.rd_match (rd_match[i]),
			.rd_in    (chain[i]),
			.rd_out   (chain[i+1]),
			.row      (rows_cur[i])
		);
	end

	assign byte_sel = chain[RowCount];
	assign nibble   = sel_next ? byte_sel[7:4] : byte_sel[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_index_q <= '0;
			sel_level_q   <= 1'b0;
			last_caps_q   <= 1'b0;
			marks_q       <= 1'b0;
		end else begin
			frame_index_q <= index_next;
			sel_level_q   <= sel_next;
			marks_q       <= marks_next;
			if (is_update) begin
				last_caps_q <= caps_key;
			end
		end
	end

	kmns_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (nibble),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (read_nibble)
	);

`ifndef SYNTH
	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_index_q <= IDX_LAST)
		else $error("frame index left the frame");
	a_clear_resets_index: assert property (@(posedge clk) disable iff (!arst_n)
		clr_rise |=> (frame_index_q == '0) && marks_q)
		else $error("rising clear did not restart the frame");
	a_caps_edge_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		is_update |=> (last_caps_q == $past(caps_key)))
		else $error("caps key level not captured");
`endif

endmodule

`default_nettype wire

// ----- tb/kmns_frame_monitor.sv -----
// ----------------------------------------------------------------------------
// kmns_frame_monitor
// Watches both channels of the nibble scanner, predicts each result nibble
// and compares it against what the block returns.
// ----------------------------------------------------------------------------
module kmns_frame_monitor (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [1:0]  command,
	input  wire  [63:0] key_rows_low,
	input  wire  [63:0] key_rows_high,
	input  wire         prev_sel,
	input  wire         next_sel,
	input  wire         prev_clr,
	input  wire         next_clr,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire  [3:0]  read_nibble,
	output int          fail_count,
	output int          due_count
);
	import kmns_pkg::*;

	localparam int ShownMax = 10;

	// Own copy of the scanner state
	logic [7:0]      key_row    [RowCount];
	logic [7:0]      frame_byte [FrameLen];
	logic [IdxW-1:0] frame_pos;
	logic            sel_lvl;
	logic            clr_lvl;
	logic            caps_key_was;

	logic [3:0] nibbles_due [$];
	logic [3:0] want;

	function automatic void clear_scanner();
		for (int r = 0; r < RowCount; r++) key_row[r] = '0;
		for (int f = 0; f < FrameLen; f++) frame_byte[f] = '0;
		frame_pos    = '0;
		sel_lvl      = 1'b0;
		clr_lvl      = 1'b0;
		caps_key_was = 1'b0;
	endfunction

	function automatic void refresh_frame_rows();
		for (int r = 0; r < RowCount; r++) frame_byte[r + 1] = ~key_row[r];
	endfunction

	// Copy the rows; the caps-lock key only toggles the stored lock bit
	function automatic void latch_keys(logic [63:0] lo, logic [63:0] hi);
		logic caps_lock;
		logic caps_key;
		caps_lock = key_row[CapsRow][CapsBit];
		for (int r = 0; r < 8; r++) begin
			key_row[r]     = lo[8*r +: 8];
			key_row[r + 8] = hi[8*r +: 8];
		end
		caps_key = key_row[CapsRow][CapsBit];
		if (!caps_key_was && caps_key) caps_lock = ~caps_lock;
		key_row[CapsRow][CapsBit] = caps_lock;
		caps_key_was = caps_key;
	endfunction

	function automatic void write_lines(logic ps, logic ns, logic pc, logic nc);
		sel_lvl = ns;
		clr_lvl = nc;
		if (!pc && nc) begin
			frame_byte[0]            = FRAME_MARK;
			refresh_frame_rows();
			frame_byte[FrameLen - 1] = FRAME_MARK;
			frame_pos                = '0;
		end else if (!ps && ns) begin
			if (frame_pos >= IDX_LAST) begin
				frame_pos = '0;
				refresh_frame_rows();
			end else begin
				frame_pos = frame_pos + IdxW'(1);
			end
		end
	endfunction

	function automatic logic [3:0] scan_word(logic [1:0] cmd, logic [63:0] lo,
			logic [63:0] hi, logic ps, logic ns, logic pc, logic nc);
		logic [7:0] cur;
		case (cmd)
			CMD_UPDATE: latch_keys(lo, hi);
			CMD_WRITE:  write_lines(ps, ns, pc, nc);
			default: ;
		endcase
		cur = (frame_pos < FrameLen) ? frame_byte[frame_pos] : 8'h00;
		return sel_lvl ? cur[7:4] : cur[3:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scanner();
			nibbles_due.delete();
			fail_count = 0;
			due_count  = 0;
		end else begin
			if (in_valid && !in_stall)
				nibbles_due.push_back(scan_word(command, key_rows_low, key_rows_high,
					prev_sel, next_sel, prev_clr, next_clr));
			if (out_valid && !out_stall) begin
				if (nibbles_due.size() == 0) begin
					fail_count++;
					if (fail_count <= ShownMax)
						$display("unexpected result word: nibble %h", read_nibble);
				end else begin
					want = nibbles_due.pop_front();
					if (read_nibble !== want) begin
						fail_count++;
						if (fail_count <= ShownMax)
							$display("read_nibble mismatch: expected %h, got %h",
								want, read_nibble);
					end
				end
			end
			due_count = nibbles_due.size();
		end
	end

endmodule

// ----- tb/keyboard_matrix_nibble_scanner_core_tb.sv -----
// ----------------------------------------------------------------------------
// keyboard_matrix_nibble_scanner_core_tb
// Drives key updates, port line writes and reads into the nibble scanner
// under random idling on both channels and gives the verdict.
// ----------------------------------------------------------------------------
// A directed opening walks through the frame build, the caps-lock toggle,
// clear against select, ignored fields and the spare command code. The random
// part is mostly well-formed console port traffic (select toggling, rare clear
// pulses) so the frame index wraps, mixed with key updates, reads and noisy
// writes. Prediction and comparison live in kmns_frame_monitor.
// ----------------------------------------------------------------------------
module keyboard_matrix_nibble_scanner_core_tb;
	import kmns_pkg::*;

	localparam logic [1:0] CMD_SPARE   = 2'd3;	// unused code, behaves as a read
	localparam int         RandWords   = 550;
	localparam int         QuietLimit  = 1000;	// cycles with no word moving
	localparam int         HoldCycles  = 120;	// long receiver hold-off
	localparam int         DrainCycles = 8;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [1:0]  command       = CMD_READ;
	logic [63:0] key_rows_low  = '0;
	logic [63:0] key_rows_high = '0;
	logic        prev_sel      = 1'b0;
	logic        next_sel      = 1'b0;
	logic        prev_clr      = 1'b0;
	logic        next_clr      = 1'b0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [3:0]  read_nibble;

	int fail_count;
	int due_count;

	// Idling stage: 0 sender 37% / receiver 50%, 1 the other way, 2 none
	int stage = 0;

	// Port line levels as the console last left them
	logic sel_now = 1'b0;
	logic clr_now = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	keyboard_matrix_nibble_scanner_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.key_rows_low  (key_rows_low),
		.key_rows_high (key_rows_high),
		.prev_sel      (prev_sel),
		.next_sel      (next_sel),
		.prev_clr      (prev_clr),
		.next_clr      (next_clr),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_nibble   (read_nibble)
	);

	kmns_frame_monitor u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.key_rows_low  (key_rows_low),
		.key_rows_high (key_rows_high),
		.prev_sel      (prev_sel),
		.next_sel      (next_sel),
		.prev_clr      (prev_clr),
		.next_clr      (next_clr),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_nibble   (read_nibble),
		.fail_count    (fail_count),
		.due_count     (due_count)
	);

	function automatic logic [63:0] any_rows();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic any_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// Offer one word: idle first at the stage's rate, then hold the payload
	// until the block takes it. Entered and left just after a falling edge.
	task automatic send_word(logic [1:0] cmd, logic [63:0] lo, logic [63:0] hi,
			logic ps, logic ns, logic pc, logic nc);
		int idle_pct;
		idle_pct = (stage == 0) ? 37 : (stage == 1) ? 50 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		key_rows_low  <= lo;
		key_rows_high <= hi;
		prev_sel      <= ps;
		next_sel      <= ns;
		prev_clr      <= pc;
		next_clr      <= nc;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		if (cmd == CMD_WRITE) begin
			sel_now = ns;
			clr_now = nc;
		end
	endtask

	// Port write that follows the current line levels, as the console would
	task automatic line_word(logic ns, logic nc);
		send_word(CMD_WRITE, any_rows(), any_rows(), sel_now, ns, clr_now, nc);
	endtask

	task automatic random_word();
		int   pick;
		logic ns;
		logic nc;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			send_word(CMD_UPDATE, any_rows(), any_rows(), any_bit(),
				any_bit(), any_bit(), any_bit());
		end else if (pick < 16) begin
			send_word((pick < 14) ? CMD_READ : CMD_SPARE, any_rows(), any_rows(),
				any_bit(), any_bit(), any_bit(), any_bit());
		end else if (pick < 20) begin
			// noise: line levels that need not match the last write
			send_word(CMD_WRITE, any_rows(), any_rows(), any_bit(),
				any_bit(), any_bit(), any_bit());
		end else begin
			// keep clear pulses rare so the index gets to wrap
			ns = ($urandom_range(0, 99) < 85) ? ~sel_now : sel_now;
			nc = clr_now ? any_bit() : ($urandom_range(0, 199) == 0);
			line_word(ns, nc);
		end
	endtask

	// Receiver: random stalls per stage, and one long hold-off as the second
	// stage starts so the output buffer fills and the input backs up.
	initial begin : result_sink
		int hold_left;
		bit held;
		hold_left = 0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stage == 1 && !held) begin
				held      = 1'b1;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				case (stage)
					0:       out_stall <= ($urandom_range(0, 99) < 50);
					1:       out_stall <= ($urandom_range(0, 99) < 37);
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	// End the run once no word has moved on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening
		send_word(CMD_READ, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);	// reset frame reads zero
		send_word(CMD_SPARE, '1, '1, 1'b1, 1'b1, 1'b1, 1'b1);	// spare code, no change
		line_word(1'b1, 1'b0);	// select rises before any clear
		send_word(CMD_UPDATE, '1, '1, 1'b1, 1'b0, 1'b1, 1'b0);	// all keys, caps key rises
		line_word(1'b0, 1'b1);	// clear rises: build frame, index 0
		line_word(1'b1, 1'b1);	// select rises with clear held high
		line_word(1'b1, 1'b1);	// no edges, levels kept
		send_word(CMD_UPDATE, '0, '0, 1'b0, 1'b1, 1'b0, 1'b1);	// caps key released
		send_word(CMD_UPDATE, '0, 64'h0010_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
		send_word(CMD_UPDATE, '0, 64'h0010_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
		line_word(1'b0, 1'b0);	// both lines fall
		send_word(CMD_WRITE, '1, '1, 1'b0, 1'b1, 1'b0, 1'b1);	// both rise: clear wins
		line_word(1'b0, 1'b0);
		line_word(1'b1, 1'b0);	// advance to index 1
		send_word(CMD_UPDATE, '1, '0, 1'b1, 1'b1, 1'b1, 1'b1);
		send_word(CMD_UPDATE, 64'hA5A5_5A5A_0F0F_F0F0, 64'h5A5A_A5A5_F0F0_0F0F,
			1'b0, 1'b0, 1'b0, 1'b0);
		line_word(1'b0, 1'b1);	// rebuild from the new rows
		line_word(1'b1, 1'b1);
		line_word(1'b0, 1'b1);
		line_word(1'b1, 1'b0);
		send_word(CMD_WRITE, '0, '0, 1'b1, 1'b1, 1'b1, 1'b0);	// levels out of step
		send_word(CMD_READ, '1, '1, 1'b1, 1'b1, 1'b1, 1'b1);	// read ignores fields

		// Random traffic through the three idling stages
		for (int n = 0; n < RandWords; n++) begin
			stage = (n < RandWords / 3) ? 0 : (n < 2 * RandWords / 3) ? 1 : 2;
			random_word();
		end
		in_valid <= 1'b0;

		// Drain: wait for the last result, then run on quietly before the verdict
		while (due_count != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/kmns_pkg.sv
rtl/kmns_row_cell.sv
rtl/kmns_out_buf.sv
rtl/keyboard_matrix_nibble_scanner_core.sv
tb/kmns_frame_monitor.sv
tb/keyboard_matrix_nibble_scanner_core_tb.sv
